FILE: rtl/source_char_tokenizer_macros.svh
// Assertion macros used by the tokenizer top module.
`ifndef SOURCE_CHAR_TOKENIZER_MACROS_SVH
`define SOURCE_CHAR_TOKENIZER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SCT_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication checked outside reset.
`define SCT_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

FILE: rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Scanner state codes, token kinds, error codes and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

    typedef enum logic [3:0] {
        S_IDLE, S_LT, S_LTLT, S_GT, S_GTGT, S_EQ, S_BANG, S_COLON,
        S_DOT, S_IDENT, S_INT, S_INTDOT, S_FRAC, S_EXPMARK, S_EXPSIGN, S_EXPDIG
    } scan_state_t;

    localparam logic [5:0] K_PLUS = 6'd30;
    localparam logic [5:0] K_MINUS = 6'd31;
    localparam logic [5:0] K_MUL = 6'd32;
    localparam logic [5:0] K_DIV = 6'd33;
    localparam logic [5:0] K_LT = 6'd34;
    localparam logic [5:0] K_LE = 6'd35;
    localparam logic [5:0] K_GE = 6'd36;
    localparam logic [5:0] K_GT = 6'd37;
    localparam logic [5:0] K_EQ = 6'd38;
    localparam logic [5:0] K_NE = 6'd39;
    localparam logic [5:0] K_DEF = 6'd40;
    localparam logic [5:0] K_ENDDEF = 6'd41;
    localparam logic [5:0] K_COLON = 6'd42;
    localparam logic [5:0] K_RANGE = 6'd43;
    localparam logic [5:0] K_SEMI = 6'd44;
    localparam logic [5:0] K_COMMA = 6'd45;
    localparam logic [5:0] K_ASSIGN = 6'd46;
    localparam logic [5:0] K_SQBO = 6'd47;
    localparam logic [5:0] K_SQBC = 6'd48;
    localparam logic [5:0] K_BO = 6'd49;
    localparam logic [5:0] K_BC = 6'd50;
    localparam logic [5:0] K_RNUM = 6'd52;
    localparam logic [5:0] K_NUM = 6'd53;
    localparam logic [5:0] K_ID = 6'd54;
    localparam logic [5:0] K_DRVDEF = 6'd55;
    localparam logic [5:0] K_DRVENDDEF = 6'd56;
    localparam logic [5:0] K_EOF = 6'd58;
    localparam logic [5:0] K_NONE = 6'd0;

    localparam logic [2:0] E_OK = 3'd0;
    localparam logic [2:0] E_PAIR = 3'd1;
    localparam logic [2:0] E_FOREIGN = 3'd2;
    localparam logic [2:0] E_REAL = 3'd3;
    localparam logic [2:0] E_LONG = 3'd4;

    localparam int WORD_DEPTH = 10;
    localparam int KW_COUNT = 30;
    localparam logic [4:0] LEN_MAX = 5'd31;

    typedef logic [8*WORD_DEPTH-1:0] word_t;

    // One token result before line stamping.
    typedef struct packed {
        logic [5:0] kind;
        logic [2:0] err;
        logic [4:0] len;
        logic       use_dot_col;
    } tok_t;

    // Keyword text, first character in the low byte, zero padded.
    function automatic word_t kw_text(input logic [4:0] idx);
        word_t w;
        string s;
        w = '0;
        case (idx)
            5'd0: s = "integer";
            5'd1: s = "real";
            5'd2: s = "boolean";
            5'd3: s = "of";
            5'd4: s = "array";
            5'd5: s = "start";
            5'd6: s = "end";
            5'd7: s = "declare";
            5'd8: s = "module";
            5'd9: s = "driver";
            5'd10: s = "program";
            5'd11:
            begin
                // The read keyword, built from its two halves.
                s = "get_";
                s = {s, "value"};
            end
            5'd12: s = "print";
            5'd13: s = "use";
            5'd14: s = "with";
            5'd15: s = "parameters";
            5'd16: s = "true";
            5'd17: s = "false";
            5'd18: s = "takes";
            5'd19: s = "input";
            5'd20: s = "returns";
            5'd21: s = "AND";
            5'd22: s = "OR";
            5'd23: s = "for";
            5'd24: s = "in";
            5'd25: s = "switch";
            5'd26: s = "case";
            5'd27: s = "break";
            5'd28: s = "default";
            5'd29: s = "while";
            default: s = "";
        endcase
        for (int i = 0; i < s.len(); i++)
        begin
            w[8*i +: 8] = s[i];
        end
        return w;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] idx);
        case (idx)
            5'd0, 5'd7, 5'd10, 5'd20, 5'd28: return 4'd7;
            5'd1, 5'd14, 5'd16, 5'd26: return 4'd4;
            5'd2: return 4'd7;
            5'd3, 5'd22, 5'd24: return 4'd2;
            5'd4, 5'd5, 5'd12, 5'd17, 5'd18, 5'd19, 5'd27, 5'd29: return 4'd5;
            5'd6, 5'd13, 5'd21, 5'd23: return 4'd3;
            5'd8, 5'd9, 5'd25: return 4'd6;
            5'd11: return 4'd9;
            5'd15: return 4'd10;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [4:0] sat_add(input logic [4:0] a, input logic [1:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {4'b0, b};
        return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[4:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sct_keyword.sv
// ----------------------------------------------------------------------------
// Keyword matcher
// Compares the stored word against all keywords in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_keyword (
    input  wire sct_pkg::word_t word,
    input  wire logic [4:0]     len,
    output logic                hit,
    output logic [4:0]          idx
);
    import sct_pkg::*;

    // Only the first len bytes take part in the compare.
    always_comb
    begin
        word_t mask;
        hit = 1'b0;
        idx = '0;
        mask = '0;
        for (int i = 0; i < WORD_DEPTH; i++)
        begin
            mask[8*i +: 8] = (i < len) ? 8'hFF : 8'h00;
        end
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if ({1'b0, kw_len(5'(k))} == len && (word & mask) == kw_text(5'(k)))
            begin
                hit = 1'b1;
                idx = 5'(k);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sct_scanner.sv
// ----------------------------------------------------------------------------
// Scanner step
// Combinational next state and up to two token results for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_scanner (
    input  wire sct_pkg::scan_state_t st,
    input  wire logic [4:0]           len,
    input  wire logic [7:0]           c,
    input  wire logic                 eoi,
    input  wire logic [3:0]           max_id,
    input  wire logic                 kw_hit,
    input  wire logic [4:0]           kw_idx,
    output sct_pkg::scan_state_t      st_next,
    output logic [4:0]                len_next,
    output logic                      begin_tok,
    output logic                      store_char,
    output logic [1:0]                n_res,
    output sct_pkg::tok_t             r0,
    output sct_pkg::tok_t             r1,
    output logic                      r0_here
);
    import sct_pkg::*;

    logic dig, let_c, expo, consumed;
    tok_t pend;
    logic pend_v;

    assign dig = c inside {["0":"9"]};
    assign let_c = c inside {["a":"z"], ["A":"Z"]};
    assign expo = c == "e" || c == "E";

    // Identifier close-out.
    function automatic tok_t ident_tok(input logic h, input logic [4:0] k,
                                       input logic [4:0] l, input logic [3:0] m);
        tok_t t;
        t = '{kind: K_ID, err: E_OK, len: l, use_dot_col: 1'b0};
        if (h)
            t.kind = {1'b0, k};
        else if (l > {1'b0, m})
        begin
            t.kind = K_NONE;
            t.err = E_LONG;
        end
        return t;
    endfunction

    always_comb
    begin
        tok_t t0, ts;
        st_next = st;
        len_next = len;
        begin_tok = 1'b0;
        store_char = 1'b0;
        pend = '0;
        pend_v = 1'b0;
        consumed = 1'b1;
        r0 = '0;
        r1 = '0;
        n_res = 2'd0;
        r0_here = 1'b0;
        t0 = '0;
        ts = '0;
        if (eoi)
        begin
            // Flush then end marker.
            pend_v = 1'b1;
            case (st)
                S_LT: pend = '{K_LT, E_OK, 5'd1, 1'b0};
                S_LTLT: pend = '{K_DEF, E_OK, 5'd2, 1'b0};
                S_GT: pend = '{K_GT, E_OK, 5'd1, 1'b0};
                S_GTGT: pend = '{K_ENDDEF, E_OK, 5'd2, 1'b0};
                S_EQ, S_BANG, S_DOT: pend = '{K_NONE, E_PAIR, 5'd1, 1'b0};
                S_COLON: pend = '{K_COLON, E_OK, 5'd1, 1'b0};
                S_IDENT: pend = ident_tok(kw_hit, kw_idx, len, max_id);
                S_INT: pend = '{K_NUM, E_OK, len, 1'b0};
                S_INTDOT: pend = '{K_NONE, E_REAL, sat_add(len, 2'd1), 1'b0};
                S_FRAC, S_EXPDIG: pend = '{K_RNUM, E_OK, len, 1'b0};
                S_EXPMARK, S_EXPSIGN: pend = '{K_NONE, E_REAL, len, 1'b0};
                default: pend_v = 1'b0;
            endcase
            st_next = S_IDLE;
            len_next = '0;
            ts = '{K_EOF, E_OK, 5'd0, 1'b0};
            if (pend_v)
            begin
                r0 = pend;
                r0_here = 1'b1;
                r1 = ts;
                n_res = 2'd2;
            end
            else
            begin
                r0 = ts;
                n_res = 2'd1;
            end
        end
        else
        begin
            // Pending token takes the byte or closes.
            case (st)
                S_LT:
                begin
                    if (c == "=") begin pend = '{K_LE, E_OK, 5'd2, 1'b0}; pend_v = 1'b1; end
                    else if (c == "<") st_next = S_LTLT;
                    else begin pend = '{K_LT, E_OK, 5'd1, 1'b0}; pend_v = 1'b1; consumed = 1'b0; end
                end
                S_LTLT:
                begin
                    pend_v = 1'b1;
                    if (c == "<") pend = '{K_DRVDEF, E_OK, 5'd3, 1'b0};
                    else begin pend = '{K_DEF, E_OK, 5'd2, 1'b0}; consumed = 1'b0; end
                end
                S_GT:
                begin
                    if (c == "=") begin pend = '{K_GE, E_OK, 5'd2, 1'b0}; pend_v = 1'b1; end
                    else if (c == ">") st_next = S_GTGT;
                    else begin pend = '{K_GT, E_OK, 5'd1, 1'b0}; pend_v = 1'b1; consumed = 1'b0; end
                end
                S_GTGT:
                begin
                    pend_v = 1'b1;
                    if (c == ">") pend = '{K_DRVENDDEF, E_OK, 5'd3, 1'b0};
                    else begin pend = '{K_ENDDEF, E_OK, 5'd2, 1'b0}; consumed = 1'b0; end
                end
                S_EQ:
                begin
                    pend_v = 1'b1;
                    pend = (c == "=") ? '{K_EQ, E_OK, 5'd2, 1'b0} : '{K_NONE, E_PAIR, 5'd2, 1'b0};
                end
                S_BANG:
                begin
                    pend_v = 1'b1;
                    pend = (c == "=") ? '{K_NE, E_OK, 5'd2, 1'b0} : '{K_NONE, E_PAIR, 5'd2, 1'b0};
                end
                S_DOT:
                begin
                    pend_v = 1'b1;
                    pend = (c == ".") ? '{K_RANGE, E_OK, 5'd2, 1'b0}
                                      : '{K_NONE, E_PAIR, 5'd2, 1'b0};
                end
                S_COLON:
                begin
                    pend_v = 1'b1;
                    if (c == "=") pend = '{K_ASSIGN, E_OK, 5'd2, 1'b0};
                    else begin pend = '{K_COLON, E_OK, 5'd1, 1'b0}; consumed = 1'b0; end
                end
                S_IDENT:
                begin
                    if (let_c || dig || c == "_")
                    begin
                        store_char = 1'b1;
                        len_next = sat_add(len, 2'd1);
                    end
                    else
                    begin
                        pend = ident_tok(kw_hit, kw_idx, len, max_id);
                        pend_v = 1'b1;
                        consumed = 1'b0;
                    end
                end
                S_INT:
                begin
                    if (dig) len_next = sat_add(len, 2'd1);
                    else if (c == ".") st_next = S_INTDOT;
                    else if (expo)
                    begin
                        len_next = sat_add(len, 2'd1);
                        st_next = S_EXPMARK;
                    end
                    else begin pend = '{K_NUM, E_OK, len, 1'b0}; pend_v = 1'b1; consumed = 1'b0; end
                end
                S_INTDOT:
                begin
                    if (c == ".")
                    begin
                        pend = '{K_NUM, E_OK, len, 1'b0};
                        pend_v = 1'b1;
                    end
                    else if (dig)
                    begin
                        len_next = sat_add(len, 2'd2);
                        st_next = S_FRAC;
                    end
                    else begin pend = '{K_NONE, E_REAL, sat_add(len, 2'd2), 1'b0}; pend_v = 1'b1; end
                end
                S_FRAC, S_EXPDIG:
                begin
                    if (dig) len_next = sat_add(len, 2'd1);
                    else if (expo && st == S_FRAC)
                    begin
                        len_next = sat_add(len, 2'd1);
                        st_next = S_EXPMARK;
                    end
                    else begin pend = '{K_RNUM, E_OK, len, 1'b0}; pend_v = 1'b1; consumed = 1'b0; end
                end
                S_EXPMARK, S_EXPSIGN:
                begin
                    if (st == S_EXPMARK && (c == "+" || c == "-"))
                    begin
                        len_next = sat_add(len, 2'd1);
                        st_next = S_EXPSIGN;
                    end
                    else if (dig)
                    begin
                        len_next = sat_add(len, 2'd1);
                        st_next = S_EXPDIG;
                    end
                    else begin pend = '{K_NONE, E_REAL, sat_add(len, 2'd1), 1'b0}; pend_v = 1'b1; end
                end
                default: consumed = 1'b0;
            endcase
            if (pend_v)
                st_next = S_IDLE;

            // A byte not taken may start a new token.
            ts = '0;
            if (!consumed)
            begin
                case (c)
                    " ", "\t", "\r", "\n": ;
                    ",": ts = '{K_COMMA, E_OK, 5'd1, 1'b0};
                    "[": ts = '{K_SQBO, E_OK, 5'd1, 1'b0};
                    "]": ts = '{K_SQBC, E_OK, 5'd1, 1'b0};
                    "(": ts = '{K_BO, E_OK, 5'd1, 1'b0};
                    ")": ts = '{K_BC, E_OK, 5'd1, 1'b0};
                    ";": ts = '{K_SEMI, E_OK, 5'd1, 1'b0};
                    "+": ts = '{K_PLUS, E_OK, 5'd1, 1'b0};
                    "-": ts = '{K_MINUS, E_OK, 5'd1, 1'b0};
                    "*": ts = '{K_MUL, E_OK, 5'd1, 1'b0};
                    "/": ts = '{K_DIV, E_OK, 5'd1, 1'b0};
                    "<": begin st_next = S_LT; begin_tok = 1'b1; end
                    ">": begin st_next = S_GT; begin_tok = 1'b1; end
                    "=": begin st_next = S_EQ; begin_tok = 1'b1; end
                    "!": begin st_next = S_BANG; begin_tok = 1'b1; end
                    ":": begin st_next = S_COLON; begin_tok = 1'b1; end
                    ".": begin st_next = S_DOT; begin_tok = 1'b1; end
                    default:
                    begin
                        if (let_c)
                        begin
                            st_next = S_IDENT;
                            begin_tok = 1'b1;
                            store_char = 1'b1;
                        end
                        else if (dig)
                        begin
                            st_next = S_INT;
                            begin_tok = 1'b1;
                        end
                        else
                            ts = '{K_NONE, E_FOREIGN, 5'd1, 1'b0};
                    end
                endcase
                if (begin_tok)
                    len_next = 5'd1;
            end
            else if (st == S_INTDOT && c == ".")
                ts = '{K_RANGE, E_OK, 5'd2, 1'b1};

            t0 = ts;
            if (pend_v && ts.len != 5'd0)
            begin
                r0 = pend;
                r0_here = 1'b1;
                r1 = ts;
                n_res = 2'd2;
            end
            else if (pend_v)
            begin
                r0 = pend;
                r0_here = 1'b1;
                n_res = 2'd1;
            end
            else if (t0.len != 5'd0)
            begin
                r0 = t0;
                n_res = 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/source_char_tokenizer.sv
// A byte accepted at one edge shows its first result in the cycle after.
// Throughput: one byte per cycle while the output is not stalled; a byte that causes
// two results holds input until its second result leaves the spare slot for the output stage.
// Reset: scanner idle, line and column at one, identifier limit at eight.
// The stored word characters are not cleared by reset.
`default_nettype none

module source_char_tokenizer #(
    parameter int LINE_BITS = 16,
    parameter int COLUMN_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [3:0]             cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             char_code,
    input  wire logic                   end_of_input,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [5:0]                  token_kind,
    output logic [2:0]                  error_code,
    output logic [LINE_BITS-1:0]        line_number,
    output logic [COLUMN_BITS-1:0]      column_number,
    output logic [4:0]                  lexeme_length,
    output logic                        last_of_run
);
    import sct_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE = COLUMN_BITS'(1);

    scan_state_t st_reg, st_next;
    logic [4:0] len_reg, len_next;
    logic [LINE_BITS-1:0] line_reg;
    logic [COLUMN_BITS-1:0] col_reg, start_reg;
    logic [3:0] max_id_reg;
    word_t word_reg;

    logic kw_hit, begin_tok, store_char, r0_here, take;
    logic [4:0] kw_idx;
    logic [1:0] n_res;
    tok_t r0, r1;

    // Output stage plus one spare slot for the second result of a byte.
    logic                   ov_reg, sv_reg;
    tok_t                   otok_reg, stok_reg;
    logic [LINE_BITS-1:0]   oline_reg, sline_reg;
    logic [COLUMN_BITS-1:0] ocol_reg, scol_reg;
    logic                   olast_reg;

    logic [COLUMN_BITS-1:0] col_r0, col_r1;

    sct_keyword u_kw (.word(word_reg), .len(len_reg), .hit(kw_hit), .idx(kw_idx));

    sct_scanner u_scan (
        .st(st_reg), .len(len_reg), .c(char_code), .eoi(end_of_input),
        .max_id(max_id_reg), .kw_hit(kw_hit), .kw_idx(kw_idx),
        .st_next(st_next), .len_next(len_next), .begin_tok(begin_tok),
        .store_char(store_char), .n_res(n_res), .r0(r0), .r1(r1), .r0_here(r0_here)
    );

    // Accept while the output slot will be free and no spare result waits.
    assign in_stall = sv_reg || (ov_reg && out_stall);
    assign take = in_valid && !in_stall;

    // Column stamps for the two results of this byte.
    always_comb
    begin
        logic [COLUMN_BITS-1:0] dot_col;
        dot_col = (col_reg > COL_ONE && col_reg < COL_MAX) ? col_reg - COL_ONE : col_reg;
        col_r0 = r0_here ? start_reg : col_reg;
        col_r1 = r1.use_dot_col ? dot_col : col_reg;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_id_reg <= 4'd8;
        else if (cfg_we)
            max_id_reg <= cfg_wdata;
    end

    // Scanner state, position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            len_reg <= '0;
            line_reg <= LINE_ONE;
            col_reg <= COL_ONE;
            start_reg <= '0;
        end
        else if (take)
        begin
            st_reg <= st_next;
            len_reg <= len_next;
            if (begin_tok)
                start_reg <= col_reg;
            if (end_of_input)
            begin
                line_reg <= LINE_ONE;
                col_reg <= COL_ONE;
            end
            else if (char_code == 8'd10)
            begin
                if (line_reg != LINE_MAX)
                    line_reg <= line_reg + LINE_ONE;
                col_reg <= COL_ONE;
            end
            else if (char_code != 8'd13 && col_reg != COL_MAX)
                col_reg <= col_reg + COL_ONE;
        end
    end

    // Identifier characters; index is the count before this byte.
    always_ff @(posedge clk)
    begin
        if (take && store_char && !end_of_input)
        begin
            if (begin_tok)
                word_reg[7:0] <= char_code;
            else if (len_reg < 5'(WORD_DEPTH))
                word_reg[8*len_reg[3:0] +: 8] <= char_code;
        end
    end

    // Output slot and spare slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            if (!ov_reg || !out_stall)
            begin
                if (sv_reg)
                begin
                    ov_reg <= 1'b1;
                    sv_reg <= 1'b0;
                end
                else
                    ov_reg <= take && n_res != 2'd0;
                if (take && n_res == 2'd2)
                    sv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || !out_stall)
        begin
            if (sv_reg)
            begin
                otok_reg <= stok_reg;
                oline_reg <= sline_reg;
                ocol_reg <= scol_reg;
                olast_reg <= 1'b1;
            end
            else
            begin
                otok_reg <= r0;
                oline_reg <= line_reg;
                ocol_reg <= col_r0;
                olast_reg <= n_res != 2'd2;
            end
            stok_reg <= r1;
            sline_reg <= line_reg;
            scol_reg <= col_r1;
        end
    end

    assign out_valid = ov_reg;
    assign token_kind = otok_reg.kind;
    assign error_code = otok_reg.err;
    assign line_number = oline_reg;
    assign column_number = ocol_reg;
    assign lexeme_length = otok_reg.len;
    assign last_of_run = olast_reg;

`include "source_char_tokenizer_macros.svh"

    `SCT_ASSERT_IMPLY(a_spare_blocks_in, clk, rst_n, sv_reg, in_stall)
    `SCT_ASSERT_IMPLY(a_spare_needs_out, clk, rst_n, sv_reg, ov_reg)
    `SCT_ASSERT_NEXT(a_pair_to_spare, clk, rst_n, take && n_res == 2'd2, sv_reg && !olast_reg)
    `SCT_ASSERT_IMPLY(a_err_kind, clk, rst_n, ov_reg && otok_reg.err != E_OK,
                      otok_reg.kind == K_NONE)

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Streams source bytes into the tokenizer with random gaps and output stalls,
// predicts every token from a behavioral scanner and checks each field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import sct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BITS = 16;
    localparam int COLUMN_BITS = 8;
    localparam logic [COLUMN_BITS-1:0] COL_TOP = '1;
    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES = 230;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } byte_item_t;

    typedef struct packed {
        logic [5:0]             kind;
        logic [2:0]             err;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [4:0]             len;
        logic                   last;
    } token_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] char_code = 8'd0;
    logic end_of_input = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [5:0] token_kind;
    logic [2:0] error_code;
    logic [LINE_BITS-1:0] line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic [4:0] lexeme_length;
    logic last_of_run;

    source_char_tokenizer #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .char_code(char_code),
        .end_of_input(end_of_input), .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .error_code(error_code), .line_number(line_number),
        .column_number(column_number), .lexeme_length(lexeme_length),
        .last_of_run(last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    byte_item_t pending_bytes[$];
    token_t expected_tokens[$];
    int errors = 0;
    int bytes_sent = 0;
    int bytes_queued = 0;
    int tokens_seen = 0;
    int idle_cycles = 0;
    bit drive_enable = 1'b0;
    logic [3:0] limits[5] = '{4'd1, 4'd10, 4'd5, 4'd15, 4'd0};

    // Scanner model state.
    scan_state_t sc_state;
    logic [7:0] sc_word[WORD_DEPTH];
    logic [4:0] sc_len;
    logic [LINE_BITS-1:0] sc_line;
    logic [COLUMN_BITS-1:0] sc_col;
    logic [COLUMN_BITS-1:0] sc_start;
    logic [3:0] sc_max_id;
    token_t step_tokens[$];

    // Every byte for the block goes through here so the end of a phase is known.
    function automatic void queue_byte(input logic [7:0] ch, input logic eoi);
        pending_bytes.push_back('{ch: ch, eoi: eoi});
        bytes_queued++;
    endfunction

    function automatic logic [4:0] len_plus(input logic [4:0] a, input int b);
        int s;
        s = a + b;
        return (s > 31) ? 5'd31 : 5'(s);
    endfunction

    function automatic bit is_digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void push_token(input logic [5:0] kind, input logic [2:0] err,
                                       input logic [COLUMN_BITS-1:0] col,
                                       input logic [4:0] len);
        token_t t;
        t.kind = kind;
        t.err = err;
        t.line = sc_line;
        t.col = col;
        t.len = len;
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void close_token(input logic [5:0] kind, input logic [2:0] err,
                                        input logic [4:0] len);
        push_token(kind, err, sc_start, len);
        sc_state = S_IDLE;
    endfunction

    // Keyword index of the stored word, or -1.
    function automatic int keyword_index();
        word_t w;
        if (sc_len > WORD_DEPTH)
            return -1;
        w = '0;
        for (int i = 0; i < WORD_DEPTH; i++)
        begin
            if (i < sc_len)
                w[8*i +: 8] = sc_word[i];
        end
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (kw_len(5'(k)) == sc_len && kw_text(5'(k)) == w)
                return k;
        end
        return -1;
    endfunction

    function automatic void close_word();
        int k;
        k = keyword_index();
        if (k >= 0)
            close_token(6'(k), E_OK, sc_len);
        else if (sc_len > {1'b0, sc_max_id})
            close_token(K_NONE, E_LONG, sc_len);
        else
            close_token(K_ID, E_OK, sc_len);
    endfunction

    function automatic void open_token(input scan_state_t st, input logic [COLUMN_BITS-1:0] col);
        sc_state = st;
        sc_start = col;
        sc_len = 5'd1;
    endfunction

    function automatic void start_char(input logic [7:0] c, input logic [COLUMN_BITS-1:0] col);
        logic [5:0] single;
        single = K_NONE;
        case (c)
            " ", "\t", 8'd13, 8'd10: return;
            ",": single = K_COMMA;
            "[": single = K_SQBO;
            "]": single = K_SQBC;
            "(": single = K_BO;
            ")": single = K_BC;
            ";": single = K_SEMI;
            "+": single = K_PLUS;
            "-": single = K_MINUS;
            "*": single = K_MUL;
            "/": single = K_DIV;
            "<": begin open_token(S_LT, col); return; end
            ">": begin open_token(S_GT, col); return; end
            "=": begin open_token(S_EQ, col); return; end
            "!": begin open_token(S_BANG, col); return; end
            ":": begin open_token(S_COLON, col); return; end
            ".": begin open_token(S_DOT, col); return; end
            default: ;
        endcase
        if (single != K_NONE)
            push_token(single, E_OK, col, 5'd1);
        else if (is_letter_ch(c))
        begin
            open_token(S_IDENT, col);
            sc_word[0] = c;
        end
        else if (is_digit_ch(c))
            open_token(S_INT, col);
        else
            push_token(K_NONE, E_FOREIGN, col, 5'd1);
    endfunction

    // Advances the open token; returns 1 when the byte was consumed.
    function automatic bit continue_token(input logic [7:0] c, input logic [COLUMN_BITS-1:0] col);
        bit expo;
        logic [COLUMN_BITS-1:0] dot_col;
        expo = (c == "e" || c == "E");
        case (sc_state)
            S_LT:
            begin
                if (c == "=") begin close_token(K_LE, E_OK, 5'd2); return 1; end
                if (c == "<") begin sc_state = S_LTLT; return 1; end
                close_token(K_LT, E_OK, 5'd1); return 0;
            end
            S_LTLT:
            begin
                if (c == "<") begin close_token(K_DRVDEF, E_OK, 5'd3); return 1; end
                close_token(K_DEF, E_OK, 5'd2); return 0;
            end
            S_GT:
            begin
                if (c == "=") begin close_token(K_GE, E_OK, 5'd2); return 1; end
                if (c == ">") begin sc_state = S_GTGT; return 1; end
                close_token(K_GT, E_OK, 5'd1); return 0;
            end
            S_GTGT:
            begin
                if (c == ">") begin close_token(K_DRVENDDEF, E_OK, 5'd3); return 1; end
                close_token(K_ENDDEF, E_OK, 5'd2); return 0;
            end
            S_EQ:
            begin
                if (c == "=") close_token(K_EQ, E_OK, 5'd2);
                else close_token(K_NONE, E_PAIR, 5'd2);
                return 1;
            end
            S_BANG:
            begin
                if (c == "=") close_token(K_NE, E_OK, 5'd2);
                else close_token(K_NONE, E_PAIR, 5'd2);
                return 1;
            end
            S_COLON:
            begin
                if (c == "=") begin close_token(K_ASSIGN, E_OK, 5'd2); return 1; end
                close_token(K_COLON, E_OK, 5'd1); return 0;
            end
            S_DOT:
            begin
                if (c == ".") close_token(K_RANGE, E_OK, 5'd2);
                else close_token(K_NONE, E_PAIR, 5'd2);
                return 1;
            end
            S_IDENT:
            begin
                if (is_letter_ch(c) || is_digit_ch(c) || c == "_")
                begin
                    if (sc_len < WORD_DEPTH)
                        sc_word[sc_len] = c;
                    sc_len = len_plus(sc_len, 1);
                    return 1;
                end
                close_word(); return 0;
            end
            S_INT:
            begin
                if (is_digit_ch(c)) begin sc_len = len_plus(sc_len, 1); return 1; end
                if (c == ".") begin sc_state = S_INTDOT; return 1; end
                if (expo)
                begin
                    sc_len = len_plus(sc_len, 1);
                    sc_state = S_EXPMARK;
                    return 1;
                end
                close_token(K_NUM, E_OK, sc_len); return 0;
            end
            S_INTDOT:
            begin
                if (c == ".")
                begin
                    // Range split: the number, then a range operator at the first dot.
                    close_token(K_NUM, E_OK, sc_len);
                    dot_col = (col > 1 && col < COL_TOP) ? col - 1'b1 : col;
                    push_token(K_RANGE, E_OK, dot_col, 5'd2);
                    return 1;
                end
                if (is_digit_ch(c))
                begin
                    sc_len = len_plus(sc_len, 2);
                    sc_state = S_FRAC;
                    return 1;
                end
                close_token(K_NONE, E_REAL, len_plus(sc_len, 2)); return 1;
            end
            S_FRAC:
            begin
                if (is_digit_ch(c)) begin sc_len = len_plus(sc_len, 1); return 1; end
                if (expo)
                begin
                    sc_len = len_plus(sc_len, 1);
                    sc_state = S_EXPMARK;
                    return 1;
                end
                close_token(K_RNUM, E_OK, sc_len); return 0;
            end
            S_EXPMARK:
            begin
                if (c == "+" || c == "-")
                begin
                    sc_len = len_plus(sc_len, 1);
                    sc_state = S_EXPSIGN;
                    return 1;
                end
                if (is_digit_ch(c))
                begin
                    sc_len = len_plus(sc_len, 1);
                    sc_state = S_EXPDIG;
                    return 1;
                end
                close_token(K_NONE, E_REAL, len_plus(sc_len, 1)); return 1;
            end
            S_EXPSIGN:
            begin
                if (is_digit_ch(c))
                begin
                    sc_len = len_plus(sc_len, 1);
                    sc_state = S_EXPDIG;
                    return 1;
                end
                close_token(K_NONE, E_REAL, len_plus(sc_len, 1)); return 1;
            end
            S_EXPDIG:
            begin
                if (is_digit_ch(c)) begin sc_len = len_plus(sc_len, 1); return 1; end
                close_token(K_RNUM, E_OK, sc_len); return 0;
            end
            default:
            begin
                sc_state = S_IDLE;
                return 0;
            end
        endcase
    endfunction

    function automatic void flush_token();
        case (sc_state)
            S_LT: close_token(K_LT, E_OK, 5'd1);
            S_LTLT: close_token(K_DEF, E_OK, 5'd2);
            S_GT: close_token(K_GT, E_OK, 5'd1);
            S_GTGT: close_token(K_ENDDEF, E_OK, 5'd2);
            S_EQ, S_BANG, S_DOT: close_token(K_NONE, E_PAIR, 5'd1);
            S_COLON: close_token(K_COLON, E_OK, 5'd1);
            S_IDENT: close_word();
            S_INT: close_token(K_NUM, E_OK, sc_len);
            S_INTDOT: close_token(K_NONE, E_REAL, len_plus(sc_len, 1));
            S_FRAC, S_EXPDIG: close_token(K_RNUM, E_OK, sc_len);
            S_EXPMARK, S_EXPSIGN: close_token(K_NONE, E_REAL, sc_len);
            default: ;
        endcase
        sc_state = S_IDLE;
    endfunction

    // Predicts the tokens caused by one accepted byte.
    function automatic void predict_tokens(input byte_item_t it);
        logic [COLUMN_BITS-1:0] col;
        token_t t;
        step_tokens.delete();
        col = sc_col;
        if (it.eoi)
        begin
            flush_token();
            push_token(K_EOF, E_OK, sc_col, 5'd0);
            sc_line = LINE_BITS'(1);
            sc_col = COLUMN_BITS'(1);
            sc_len = 5'd0;
        end
        else
        begin
            if (!continue_token(it.ch, col))
                start_char(it.ch, col);
            if (it.ch == 8'd10)
            begin
                if (sc_line != LINE_TOP)
                    sc_line++;
                sc_col = COLUMN_BITS'(1);
            end
            else if (it.ch != 8'd13 && sc_col != COL_TOP)
                sc_col++;
        end
        for (int i = 0; i < step_tokens.size(); i++)
        begin
            t = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endfunction

    // Driver: presents queued bytes with random gaps.
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_tokens('{ch: char_code, eoi: end_of_input});
            bytes_sent++;
        end
        if (in_valid && in_stall)
            ;
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (drive_enable && pending_bytes.size() > 0)
        begin
            byte_item_t it;
            it = pending_bytes.pop_front();
            in_valid <= 1'b1;
            char_code <= it.ch;
            end_of_input <= it.eoi;
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        end
        else
            in_valid <= 1'b0;
    end

    // Monitor: checks each accepted token against the oldest prediction.
    int stall_left = 0;
    always @(posedge clk)
    begin
        token_t exp_tok;
        if (rst_n && out_valid && !out_stall)
        begin
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d", token_kind);
                errors++;
            end
            else
            begin
                exp_tok = expected_tokens.pop_front();
                if (token_kind !== exp_tok.kind)
                begin
                    $error("token_kind: expected %0d, got %0d", exp_tok.kind, token_kind);
                    errors++;
                end
                if (error_code !== exp_tok.err)
                begin
                    $error("error_code: expected %0d, got %0d", exp_tok.err, error_code);
                    errors++;
                end
                if (line_number !== exp_tok.line)
                begin
                    $error("line_number: expected %0d, got %0d", exp_tok.line, line_number);
                    errors++;
                end
                if (column_number !== exp_tok.col)
                begin
                    $error("column_number: expected %0d, got %0d", exp_tok.col,
                           column_number);
                    errors++;
                end
                if (lexeme_length !== exp_tok.len)
                begin
                    $error("lexeme_length: expected %0d, got %0d", exp_tok.len,
                           lexeme_length);
                    errors++;
                end
                if (last_of_run !== exp_tok.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", exp_tok.last, last_of_run);
                    errors++;
                end
            end
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d items pending", pending_bytes.size());
            $display("source_char_tokenizer regression: fail");
            $finish;
        end
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], 1'b0);
    endtask

    task automatic add_end();
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Random well-formed fragment, sometimes noise.
    task automatic add_fragment();
        string frags[] = '{"<<<", ">>>", "<<", ">>", "<=", ">=", "==", "!=", ":=", ":",
                           "..", "<", ">", ",", ";", "[", "]", "(", ")", "+", "-", "*",
                           "/", "integer", "parameters", "returns", "AND",
                           "OR", "while", "x_1", "abcdefghijk", "Zq9", "12..", "3.25",
                           "7e+5", "1.5E-3", "4e", "9.x", "5.", "=x", "!a", ".b", "\n",
                           " ", "\t", "\r", "@", "parametersX", "getvalue"};
        int n;
        case ($urandom_range(0, 9))
            0: queue_byte(8'($urandom_range(0, 255)), 1'b0);
            1:
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    queue_byte(8'($urandom_range(97, 122)), 1'b0);
            end
            2:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    queue_byte(8'($urandom_range(48, 57)), 1'b0);
            end
            3:
            begin
                // The nine-character keyword with an underscore.
                add_text("get_");
                add_text("value");
            end
            default: add_text(frags[$urandom_range(0, frags.size() - 1)]);
        endcase
        if ($urandom_range(0, 2) == 0)
            add_text(" ");
    endtask

    // Waits until every queued byte went in and every token came out.
    task automatic drain();
        while (bytes_sent < bytes_queued || expected_tokens.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limit(input logic [3:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sc_max_id = v;
    endtask

    initial
    begin
        sc_state = S_IDLE;
        sc_len = 5'd0;
        sc_line = LINE_BITS'(1);
        sc_col = COLUMN_BITS'(1);
        sc_start = '0;
        sc_max_id = 4'd8;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_enable = 1'b1;

        // Directed: operators but the lone < and >, keywords, numbers, errors, long words, bytes.
        add_text("<<< >>> << >> <= >= == != := : .. , ; [ ] ( ) + - * /\n");
        add_text("integer abcdefghi 12..5 3.5e+2 4e 7.x =a !b .c 8E5\r\n");
        add_text("parameters\t");
        queue_byte(8'd0, 1'b0);
        queue_byte(8'd255, 1'b0);
        add_text("9.");
        add_end();
        add_text("=");
        add_end();
        drain();

        // Random phases at several identifier limits, each ending the text.
        for (int p = 0; p < $size(limits); p++)
        begin
            write_limit(limits[p]);
            while (pending_bytes.size() < PHASE_BYTES)
                add_fragment();
            // In the third phase a long line reaches column saturation.
            if (p == 2)
                repeat (260) add_text("a");
            add_end();
            drive_enable = 1'b1;
            drain();
        end

        $display("bytes accepted: %0d, tokens checked: %0d, limits tried: 8 1 10 5 15 0",
                 bytes_sent, tokens_seen);
        if (errors == 0)
            $display("source_char_tokenizer regression: pass");
        else
            $display("source_char_tokenizer regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
